>>> rtl/core/edb_pkg.sv
// edb_pkg: widths, types and register codes of the error diffusion binarizer
// no dependencies; imported by the channel interfaces and the top level
`default_nettype none

package edb_pkg;

  localparam int GREY_W    = 8;
  localparam int ERR_W     = 12;
  localparam int LW_W      = 10;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = LW_W;

  localparam int MAX_COLUMNS_DEF = 1024;
  localparam logic [LW_W-1:0] LINE_WIDTH_RST = LW_W'(162);

  // signed error as kept in the line buffer and the carry
  typedef logic signed [ERR_W-1:0]   err_t;
  // pixel plus carried error
  typedef logic signed [ERR_W:0]     val_t;
  // error sums before saturation
  typedef logic signed [ERR_W+1:0]   sum_t;
  // error times a weight numerator
  typedef logic signed [ERR_W+3:0]   prod_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WEIGHT_MODE = CFG_IDX_W'(0),
    CFG_LINE_WIDTH  = CFG_IDX_W'(1)
  } cfg_idx_t;

  localparam sum_t ERR_MAX_S = sum_t'(2047);
  localparam sum_t ERR_MIN_S = sum_t'(-2048);

endpackage

`default_nettype wire

>>> rtl/core/edb_pix_if.sv
// edb_pix_if: grey pixel channel, one pixel per beat
// depends on edb_pkg
`default_nettype none

interface edb_pix_if import edb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [GREY_W-1:0] grey;

  modport source (output valid, output grey, input ready);
  modport sink   (input valid, input grey, output ready);
endinterface

`default_nettype wire

>>> rtl/core/edb_dot_if.sv
// edb_dot_if: bilevel dot channel, one dot per beat with its row-end flag
// depends on edb_pkg
`default_nettype none

interface edb_dot_if import edb_pkg::*; ();
  logic valid;
  logic ready;
  logic dot_on;
  logic row_end;

  modport source (output valid, output dot_on, output row_end, input ready);
  modport sink   (input valid, input dot_on, input row_end, output ready);
endinterface

`default_nettype wire

>>> rtl/core/edb_cfg_if.sv
// edb_cfg_if: register write channel, index and data per beat
// depends on edb_pkg
`default_nettype none

interface edb_cfg_if import edb_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/error_diffusion_binarizer.sv
// error_diffusion_binarizer: top level, line-buffer error diffusion to one dot per pixel
// depends on edb_pkg, edb_pix_if, edb_dot_if, edb_cfg_if
//
// usage
//   pix  : grey pixels in raster order, one per beat
//   dot  : one beat per pixel, dot_on (white) and row_end (last pixel of its row)
//   cfg  : register writes, index 0 weight_mode, index 1 line_width; always ready,
//          write only while no pixel is in flight
//   path: a pixel taken is registered in the compute stage, then its dot in
//          the output register that drives the dot port
//   throughput: one pixel per cycle while dot is taken and no clearing pass
//          runs; the loop that sets it is the carried right-hand error: add,
//          threshold, weight and add of the line-buffer word, all combinational in the compute stage
//   line buffer: one synchronous memory of MAX_COLUMNS words, one read (entry
//          col+1) and one write per cycle; entries col-1 and col stay in
//          registers until final, entry 0 lives in a register
//   reset: rst clears the control state, then a clearing pass writes zero to
//          every line-buffer word while pix is held not ready (cfg writes still taken)
//   stall: when dot is not taken the result waits in the output register and
//          one more pixel is taken and held in the compute stage; after that
//          pix.ready drops until the output register frees
`default_nettype none

module error_diffusion_binarizer import edb_pkg::*; #(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  edb_pix_if.sink    pix,
  edb_dot_if.source  dot,
  edb_cfg_if.sink    cfg
);

  localparam int COL_W = $clog2(MAX_COLUMNS);
  localparam int CNT_W = $clog2(MAX_COLUMNS + 1);
  localparam int CMP_W = (CNT_W > LW_W) ? CNT_W : LW_W;

  // deferred line-buffer write left over from a row end
  typedef struct packed {
    logic [COL_W-1:0] addr;
    err_t             data;
  } wb_t;

  // ---------------------------------------------------------------------------
  // arithmetic helpers
  // ---------------------------------------------------------------------------
  function automatic err_t sat_err(input sum_t x);
    if (x > ERR_MAX_S) return err_t'(ERR_MAX_S);
    if (x < ERR_MIN_S) return err_t'(ERR_MIN_S);
    return x[ERR_W-1:0];
  endfunction

  // divide by 16, truncating toward zero
  function automatic err_t div16(input prod_t x);
    prod_t t;
    prod_t q;
    t = x[ERR_W+3] ? x + prod_t'(15) : x;
    q = t >>> 4;
    return q[ERR_W-1:0];
  endfunction

  // divide by 8, truncating toward zero
  function automatic err_t div8(input prod_t x);
    prod_t t;
    prod_t q;
    t = x[ERR_W+3] ? x + prod_t'(7) : x;
    q = t >>> 3;
    return q[ERR_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  logic             weight_mode;
  logic [LW_W-1:0]  line_width;

  logic             clr_busy;
  logic [COL_W-1:0] clr_addr;

  logic [COL_W-1:0] col;

  // compute stage
  logic              b_valid;
  logic [GREY_W-1:0] b_grey;
  logic [COL_W-1:0]  b_col;
  logic [COL_W-1:0]  b_addr;
  logic              b_end;
  logic              b_rd_zero;
  logic              byp_hit;
  err_t              byp_data;

  // diffusion state
  err_t carry;
  err_t win_prev;   // entry col-1, still open for the below-left part
  err_t win_cur;    // entry col, holds the below-right part of the last pixel
  err_t row0;       // entry 0 of the line buffer

  // line buffer
  err_t mem [MAX_COLUMNS];
  err_t rd_q;

  // row-end write queue, slot 0 oldest
  logic [1:0] q_valid;
  wb_t        q_ent [2];

  // output register
  logic o_valid;
  logic o_dot;
  logic o_end;

  // ---------------------------------------------------------------------------
  // input side: column counter and read of entry col+1
  // ---------------------------------------------------------------------------
  logic             accept;
  logic             b_adv;
  logic [CNT_W-1:0] col_inc;
  logic             a_end;
  logic             a_zero;
  logic [COL_W-1:0] rd_addr;

  assign b_adv     = b_valid && (!o_valid || dot.ready);
  assign pix.ready = !clr_busy && (!b_valid || b_adv);
  assign accept    = pix.valid && pix.ready;

  assign col_inc = CNT_W'(col) + CNT_W'(1);
  assign a_zero  = (col_inc == CNT_W'(MAX_COLUMNS));
  // a zero line width never matches, so the row runs to the buffer end
  assign a_end   = (CMP_W'(col_inc) == CMP_W'(line_width)) || a_zero;
  assign rd_addr = col_inc[COL_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
    end else if (accept) begin
      col <= a_end ? '0 : col_inc[COL_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------------
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      weight_mode <= 1'b0;
      line_width  <= LINE_WIDTH_RST;
    end else if (cfg.valid) begin
      unique case (cfg_idx_t'(cfg.index))
        CFG_WEIGHT_MODE: weight_mode <= cfg.data[0];
        CFG_LINE_WIDTH:  line_width  <= cfg.data[LW_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // compute stage
  // ---------------------------------------------------------------------------
  err_t  rd_val;
  val_t  v;
  val_t  v_err;
  logic  white;
  err_t  err;
  prod_t err_x;
  err_t  e_right;
  err_t  e_bl;
  err_t  e_below;
  sum_t  br_sum;
  err_t  e_br;
  err_t  carry_run;
  err_t  prev_fin;
  err_t  cur_new;
  err_t  entry0;
  logic  b_wr_prev;

  // newest copy of entry col+1: zero past the buffer end, queued row-end
  // writes, a write after the read was issued, then the memory word
  always_comb begin
    if (b_rd_zero) begin
      rd_val = '0;
    end else if (q_valid[1] && q_ent[1].addr == b_addr) begin
      rd_val = q_ent[1].data;
    end else if (q_valid[0] && q_ent[0].addr == b_addr) begin
      rd_val = q_ent[0].data;
    end else if (byp_hit) begin
      rd_val = byp_data;
    end else begin
      rd_val = rd_q;
    end
  end

  assign v     = val_t'(b_grey) + val_t'(carry);
  assign white = (v > val_t'(127));
  assign v_err = white ? v - val_t'(255) : v;
  assign err   = v_err[ERR_W-1:0];
  assign err_x = prod_t'(err);

  always_comb begin
    if (weight_mode) begin
      e_right = div16(err_x * prod_t'(7));
      e_bl    = div16(err_x * prod_t'(3));
      e_below = div16(err_x * prod_t'(5));
    end else begin
      e_right = div8(err_x * prod_t'(3));
      e_bl    = div8(err_x);
      e_below = e_right;
    end
  end

  // the remainder of the error, rounding included, goes below-right
  assign br_sum = sum_t'(err) - sum_t'(e_right) - sum_t'(e_bl) - sum_t'(e_below);
  assign e_br   = sat_err(br_sum);

  assign carry_run = sat_err(sum_t'(rd_val) + sum_t'(e_right));
  assign prev_fin  = sat_err(sum_t'(win_prev) + sum_t'(e_bl));
  assign cur_new   = sat_err(sum_t'(win_cur) + sum_t'(e_below));

  // entry 0 as it stands at a row end: still open in the window on a row of
  // one or two pixels, else in its own register
  always_comb begin
    if (b_col == '0) begin
      entry0 = cur_new;
    end else if (b_col == COL_W'(1)) begin
      entry0 = prev_fin;
    end else begin
      entry0 = row0;
    end
  end

  // entry col-1 is final; entry 0 goes to row0, higher ones to memory
  assign b_wr_prev = (CNT_W'(b_col) >= CNT_W'(2));

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (accept) begin
      b_valid <= 1'b1;
    end else if (b_adv) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_grey    <= pix.grey;
      b_col     <= col;
      b_addr    <= rd_addr;
      b_end     <= a_end;
      b_rd_zero <= a_zero;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      carry   <= '0;
      win_cur <= '0;
      row0    <= '0;
    end else if (b_adv) begin
      if (b_col == COL_W'(1)) begin
        row0 <= prev_fin;
      end
      if (b_end) begin
        carry   <= entry0;
        win_cur <= '0;
      end else begin
        carry    <= carry_run;
        win_prev <= cur_new;
        win_cur  <= e_br;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // line buffer write port: clearing pass, final entry col-1, queue drain
  // ---------------------------------------------------------------------------
  logic             mem_we;
  logic [COL_W-1:0] mem_wa;
  err_t             mem_wd;
  logic             q_pop;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = clr_addr;
    mem_wd = '0;
    q_pop  = 1'b0;
    if (clr_busy) begin
      mem_we = 1'b1;
    end else if (b_adv && b_wr_prev) begin
      mem_we = 1'b1;
      mem_wa = b_col - COL_W'(1);
      mem_wd = prev_fin;
    end else if (q_valid[0]) begin
      mem_we = 1'b1;
      mem_wa = q_ent[0].addr;
      mem_wd = q_ent[0].data;
      q_pop  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (accept) begin
      rd_q <= mem[rd_addr];
    end
  end

  // catch a write to the word being read, at the read or while stalled
  always_ff @(posedge clk) begin
    if (accept) begin
      byp_hit  <= mem_we && (mem_wa == rd_addr);
      byp_data <= mem_wd;
    end else if (b_valid && !b_adv && mem_we && (mem_wa == b_addr)) begin
      byp_hit  <= 1'b1;
      byp_data <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + COL_W'(1);
      if (clr_addr == COL_W'(MAX_COLUMNS - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // row end leaves entries col and col+1 open; they wait here for free write
  // slots, which the first two pixels of the next row always provide
  logic [3:0] cand_v;
  wb_t        cand [4];
  logic [1:0] q_valid_next;
  wb_t        q_ent_next [2];
  logic [1:0] q_n;

  always_comb begin
    cand_v[0] = q_pop ? q_valid[1] : q_valid[0];
    cand[0]   = q_pop ? q_ent[1] : q_ent[0];
    cand_v[1] = q_pop ? 1'b0 : q_valid[1];
    cand[1]   = q_ent[1];
    cand_v[2] = b_adv && b_end && (b_col != '0);
    cand[2]   = '{addr: b_col, data: cur_new};
    cand_v[3] = b_adv && b_end && !b_rd_zero;
    cand[3]   = '{addr: b_addr, data: e_br};
  end

  always_comb begin
    q_n          = '0;
    q_valid_next = '0;
    q_ent_next   = q_ent;
    for (int i = 0; i < 4; i++) begin
      if (cand_v[i] && (q_n != 2'd2)) begin
        q_ent_next[q_n[0]]   = cand[i];
        q_valid_next[q_n[0]] = 1'b1;
        q_n                  = q_n + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= '0;
    end else begin
      q_valid <= q_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    q_ent <= q_ent_next;
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (b_adv) begin
      o_valid <= 1'b1;
    end else if (dot.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      o_dot <= white;
      o_end <= b_end;
    end
  end

  assign dot.valid   = o_valid;
  assign dot.dot_on  = o_dot;
  assign dot.row_end = o_end;

endmodule

`default_nettype wire
